// ----- rtl/core/bgd_pkg.sv -----
// Shared types and constants for the button gesture detector.
package bgd_pkg;

    // Input sample: pressed pattern and millisecond timestamp
    typedef struct packed {
        logic [2:0]  buttons;
        logic [31:0] now_ms;
    } in_item_t;

    // Result: gesture code and the button combination it belongs to
    typedef struct packed {
        logic [1:0] gesture;
        logic [2:0] combo;
    } out_item_t;

    // Timing configuration
    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] double_click_ms;
    } cfg_regs_t;

    // Gesture codes
    localparam logic [1:0] GESTURE_CLICK  = 2'd0;
    localparam logic [1:0] GESTURE_DOUBLE = 2'd1;
    localparam logic [1:0] GESTURE_LONG   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [1:0] CFG_LONG_PRESS   = 2'd1;
    localparam logic [1:0] CFG_DOUBLE_CLICK = 2'd2;

    // Register reset values
    localparam logic [15:0] DEBOUNCE_RESET     = 16'd20;
    localparam logic [15:0] LONG_PRESS_RESET   = 16'd500;
    localparam logic [15:0] DOUBLE_CLICK_RESET = 16'd150;

    // Click counter saturation and the count that means a double click
    localparam logic [2:0] CLICK_MAX    = 3'd7;
    localparam logic [2:0] CLICK_DOUBLE = 3'd2;

endpackage

// ----- rtl/core/bgd_cfg_regs.sv -----
// Configuration register file for the button gesture detector.
module bgd_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [1:0]        wr_index,
    input  logic [15:0]       wr_data,
    output bgd_pkg::cfg_regs_t cfg
);
    import bgd_pkg::*;

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_DEBOUNCE:     cfg_next.debounce_ms     = wr_data;
                CFG_LONG_PRESS:   cfg_next.long_press_ms   = wr_data;
                CFG_DOUBLE_CLICK: cfg_next.double_click_ms = wr_data;
                default:          cfg_next = cfg_reg;  // drop writes beyond the list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms     <= DEBOUNCE_RESET;
            cfg_reg.long_press_ms   <= LONG_PRESS_RESET;
            cfg_reg.double_click_ms <= DOUBLE_CLICK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/bgd_engine.sv -----
// Gesture state registers and the single-pass update for one sample.
module bgd_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  bgd_pkg::in_item_t  sample,
    input  bgd_pkg::cfg_regs_t cfg,
    output logic               report,
    output bgd_pkg::out_item_t result
);
    import bgd_pkg::*;

    logic [2:0]  pattern_reg, pattern_next;
    logic [2:0]  combo_reg, combo_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [2:0]  count_reg, count_next;
    logic        long_reg, long_next;

    logic [31:0] elapsed;
    logic [31:0] elapsed_after;
    logic [2:0]  count_inc;
    logic        change;
    logic [2:0]  combo_mid;
    logic [2:0]  count_mid;
    logic        long_mid;
    logic [31:0] stamp_mid;

    assign elapsed   = sample.now_ms - stamp_reg;
    assign change    = (sample.buttons != pattern_reg) && (elapsed > {16'd0, cfg.debounce_ms});
    assign count_inc = (count_reg < CLICK_MAX) ? count_reg + 3'd1 : count_reg;

    // Debounced pattern change; elapsed_after is now minus the updated stamp
    always_comb
    begin
        pattern_next  = pattern_reg;
        combo_mid     = combo_reg;
        stamp_mid     = stamp_reg;
        count_mid     = count_reg;
        long_mid      = long_reg;
        elapsed_after = elapsed;
        if (change)
        begin
            if (sample.buttons > pattern_reg)
            begin
                stamp_mid     = sample.now_ms;
                pattern_next  = sample.buttons;
                combo_mid     = sample.buttons;
                elapsed_after = 32'd0;
            end
            else if (sample.buttons == 3'd0)
            begin
                count_mid    = count_inc;
                pattern_next = 3'd0;
                if (elapsed >= {16'd0, cfg.long_press_ms})
                begin
                    long_mid      = 1'b1;
                    stamp_mid     = 32'd0;
                    elapsed_after = sample.now_ms;
                end
                else
                begin
                    long_mid = 1'b0;
                    if (count_inc > 3'd1)
                    begin
                        stamp_mid     = 32'd0;
                        elapsed_after = sample.now_ms;
                    end
                    else
                    begin
                        stamp_mid     = sample.now_ms;
                        elapsed_after = 32'd0;
                    end
                end
            end
            else
            begin
                // partial release: restart the stamp only
                stamp_mid     = sample.now_ms;
                elapsed_after = 32'd0;
            end
        end
    end

    // Report once the quiet window has passed with releases pending
    always_comb
    begin
        report     = (elapsed_after > {16'd0, cfg.double_click_ms}) && (count_mid != 3'd0);
        combo_next = combo_mid;
        stamp_next = stamp_mid;
        count_next = count_mid;
        long_next  = long_mid;
        if (long_mid)
        begin
            result.gesture = GESTURE_LONG;
        end
        else if (count_mid == CLICK_DOUBLE)
        begin
            result.gesture = GESTURE_DOUBLE;
        end
        else
        begin
            result.gesture = GESTURE_CLICK;
        end
        result.combo = combo_mid;
        if (report)
        begin
            combo_next = 3'd0;
            stamp_next = 32'd0;
            count_next = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= 3'd0;
            combo_reg   <= 3'd0;
            stamp_reg   <= 32'd0;
            count_reg   <= 3'd0;
            long_reg    <= 1'b0;
        end
        else if (step)
        begin
            pattern_reg <= pattern_next;
            combo_reg   <= combo_next;
            stamp_reg   <= stamp_next;
            count_reg   <= count_next;
            long_reg    <= long_next;
        end
    end

endmodule

// ----- rtl/core/button_gesture_detector_core.sv -----
// Top level of the button gesture detector: handshakes, sample and result registers.
//
//  Channel | Signals                            | Direction | Moves
//  --------+------------------------------------+-----------+--------------------------
//  in      | in_valid, in_ready, in_item        | sink      | one sample per transfer
//  out     | out_valid, out_ready, out_item     | source    | one gesture per transfer
//  cfg     | cfg_valid, cfg_ready, cfg_index,   | sink      | one register write per
//          | cfg_data                           |           | transfer, always ready
//
// Flow: a sample transfer lands in the sample register; once the result register
// can take a gesture, the engine updates the gesture state and, when a gesture is
// due, loads the result register, which drives out_valid. One sample
// is taken every cycle while the result side keeps up.
// Reset: rst_n clears the gesture state, both valid flags and loads the
// register defaults (debounce 20, long press 500, double click 150).
// Stalls: while a result waits in the result register and out_ready is low, the
// sample register holds; in_ready drops only when that register is full too.
module button_gesture_detector_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bgd_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output bgd_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import bgd_pkg::*;

    // Sample register
    logic       s1_valid_reg, s1_valid_next;
    in_item_t   s1_item_reg;

    // Result register
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg;

    cfg_regs_t  cfg;
    logic       out_free;
    logic       step;
    logic       report;
    out_item_t  result;

    // Configuration writes are taken at once
    assign cfg_ready = 1'b1;

    bgd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Advance the held sample only when the result register can take a gesture
    assign out_free = !out_valid_reg || out_ready;
    assign step     = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || step;

    bgd_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .sample (s1_item_reg),
        .cfg    (cfg),
        .report (report),
        .result (result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && report)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
        if (step && report)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // An empty sample register always takes a new transfer
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("in_ready low with empty sample register");

    // A held sample with a blocked result stays put
    a_sample_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |=> s1_valid_reg)
        else $error("sample dropped while result stalled");

    // Only defined gesture codes leave the block
    a_gesture_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.gesture == GESTURE_CLICK ||
                       out_item.gesture == GESTURE_DOUBLE ||
                       out_item.gesture == GESTURE_LONG))
        else $error("undefined gesture code");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the button gesture detector core.
`timescale 1ns / 100ps

module testbench;
    import bgd_pkg::*;

    localparam int STALL_LIMIT = 2000;  // cycles with no transfer at all
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int SETTLE_PAD  = 6;     // engine latency plus margin
    localparam int PHASE_ITEMS = 128;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Stimulus and scoreboard storage
    in_item_t    sample_q[$];
    out_item_t   gesture_q[$];
    int          send_idle = 36;
    int          recv_idle = 76;
    bit          hold_go = 1'b0;
    int          fault_count = 0;
    int          queued_samples = 0;
    logic [31:0] sample_time = '0;

    // Gesture tracker state, owned by the scoreboard process
    cfg_regs_t   regs;
    logic [2:0]  trk_pattern;
    logic [2:0]  trk_combo;
    logic [2:0]  trk_clicks;
    logic [31:0] trk_stamp;
    logic        trk_long;

    // Receiver side: hold-off bookkeeping
    int          hold_left;
    bit          hold_used;
    int          quiet_cycles;

    button_gesture_detector_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Advance the tracker by one sample; return 1 when a gesture is due.
    function automatic bit track_gesture(input in_item_t s, output out_item_t g);
        logic [31:0] elapsed;
        bit          due;
        elapsed = s.now_ms - trk_stamp;
        due = 1'b0;
        g = '0;
        // Accept a change only once the debounce time has run out
        if (s.buttons != trk_pattern && elapsed > {16'h0000, regs.debounce_ms})
        begin
            if (s.buttons > trk_pattern)
            begin
                // Growing pattern: record the combination, restart timing
                trk_stamp = s.now_ms;
                trk_pattern = s.buttons;
                trk_combo = s.buttons;
            end
            else if (s.buttons == 3'd0)
            begin
                // Full release: count it, decide long or short
                if (trk_clicks < CLICK_MAX)
                    trk_clicks = trk_clicks + 3'd1;
                if (elapsed >= {16'h0000, regs.long_press_ms})
                begin
                    trk_stamp = '0;
                    trk_long = 1'b1;
                end
                else
                begin
                    trk_long = 1'b0;
                    trk_stamp = (trk_clicks > 3'd1) ? 32'd0 : s.now_ms;
                end
                trk_pattern = 3'd0;
            end
            else
            begin
                // Partial release only restarts the stamp
                trk_stamp = s.now_ms;
            end
        end
        // Report once the double-click window has passed
        if ((s.now_ms - trk_stamp) > {16'h0000, regs.double_click_ms} && trk_clicks != 3'd0)
        begin
            if (trk_long)
                g.gesture = GESTURE_LONG;
            else if (trk_clicks == CLICK_DOUBLE)
                g.gesture = GESTURE_DOUBLE;
            else
                g.gesture = GESTURE_CLICK;
            g.combo = trk_combo;
            trk_clicks = 3'd0;
            trk_stamp = '0;
            trk_combo = 3'd0;
            due = 1'b1;
        end
        return due;
    endfunction

    task automatic log_fault(input string msg);
        if (fault_count < 10)
            $display("%0t: %s", $time, msg);
        fault_count++;
    endtask

    // Sender: load the next pending sample whenever the slot is free
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                in_item <= sample_q.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random back-pressure plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_go && !hold_used)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Scoreboard: mirror register writes, predict on sample transfers,
    // check on result transfers
    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        out_item_t want;
        if (!rst_n)
        begin
            regs.debounce_ms = DEBOUNCE_RESET;
            regs.long_press_ms = LONG_PRESS_RESET;
            regs.double_click_ms = DOUBLE_CLICK_RESET;
            trk_pattern = '0;
            trk_combo = '0;
            trk_clicks = '0;
            trk_stamp = '0;
            trk_long = 1'b0;
            gesture_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE:     regs.debounce_ms = cfg_data;
                    CFG_LONG_PRESS:   regs.long_press_ms = cfg_data;
                    CFG_DOUBLE_CLICK: regs.double_click_ms = cfg_data;
                    default:          ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (gesture_q.size() == 0)
                    log_fault($sformatf("unexpected result gesture=%0d combo=%0d",
                                        out_item.gesture, out_item.combo));
                else
                begin
                    want = gesture_q.pop_front();
                    if (out_item.gesture !== want.gesture || out_item.combo !== want.combo)
                        log_fault($sformatf({"mismatch: expected gesture=%0d combo=%0d,",
                                             " got gesture=%0d combo=%0d"},
                                            want.gesture, want.combo,
                                            out_item.gesture, out_item.combo));
                end
            end
            if (in_valid && in_ready)
            begin
                if (track_gesture(in_item, want))
                    gesture_q.push_back(want);
            end
        end
    end

    // Watchdog: end the run when nothing has moved for too long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_sample(input logic [2:0] pattern, input logic [31:0] stamp);
        in_item_t s;
        s.buttons = pattern;
        s.now_ms = stamp;
        sample_q.push_back(s);
        queued_samples++;
    endtask

    // Write one register; the transfer lands on the edge after cfg_ready is seen
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every sample to be taken and every gesture to come out
    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_q.size() != 0 || in_valid || gesture_q.size() != 0);
        repeat (SETTLE_PAD) @(negedge clk);
    endtask

    // One well-formed gesture: presses, holds and releases with random
    // timing around the current thresholds, then quiet samples
    task automatic add_gesture();
        logic [2:0]  combo;
        logic [31:0] deb;
        logic [31:0] lp;
        logic [31:0] dc;
        logic [31:0] span;
        int          clicks;
        deb = {16'h0000, regs.debounce_ms};
        lp = {16'h0000, regs.long_press_ms};
        dc = {16'h0000, regs.double_click_ms};
        combo = 3'($urandom_range(7, 1));
        clicks = ($urandom_range(7) == 0) ? $urandom_range(10, 3) : $urandom_range(2, 1);
        // Jump near time zero (cleared stamp) or just below the wrap point
        if ($urandom_range(7) == 0)
            sample_time = $urandom_range(400);
        else if ($urandom_range(15) == 0)
            sample_time = 32'hFFFF_FFFF - $urandom_range(3000);
        for (int k = 0; k < clicks; k++)
        begin
            sample_time += deb + 1 + $urandom_range(30);
            if (combo > 3'd1 && $urandom_range(3) == 0)
            begin
                // Start with a subset, then grow to the full combination
                push_sample(3'($urandom_range(combo - 1, 1)), sample_time);
                sample_time += deb + 1 + $urandom_range(10);
            end
            push_sample(combo, sample_time);
            if (deb > 1 && $urandom_range(3) == 0)
                push_sample(3'($urandom_range(7)), sample_time + $urandom_range(deb - 1, 1));
            if ($urandom_range(2) == 0)
                sample_time += lp + $urandom_range(60);
            else
            begin
                span = (lp > deb + 2) ? lp - deb - 3 : 32'd0;
                sample_time += deb + 1 + $urandom_range(span);
            end
            if (combo > 3'd1 && $urandom_range(4) == 0)
            begin
                // Partial release before letting go completely
                push_sample(3'($urandom_range(combo - 1, 1)), sample_time);
                sample_time += deb + 1 + $urandom_range(10);
            end
            push_sample(3'd0, sample_time);
            sample_time += deb + 1 + $urandom_range(dc / 2 + 1);
        end
        if ($urandom_range(1) == 0)
        begin
            sample_time += $urandom_range(dc);
            push_sample(3'd0, sample_time);
        end
        sample_time += dc + 1 + $urandom_range(20);
        push_sample(3'd0, sample_time);
    endtask

    // Noise: random patterns at random or nearby times
    task automatic add_noise();
        int n;
        n = $urandom_range(4, 1);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(1) == 0)
                push_sample(3'($urandom_range(7)), $urandom());
            else
            begin
                sample_time += $urandom_range(3 * regs.debounce_ms + 5);
                push_sample(3'($urandom_range(7)), sample_time);
            end
        end
    endtask

    task automatic run_phase(input int s_idle, input int r_idle, input bit hold);
        int target;
        send_idle = s_idle;
        recv_idle = r_idle;
        target = queued_samples + PHASE_ITEMS;
        while (queued_samples < target)
        begin
            if ($urandom_range(99) < 85)
                add_gesture();
            else
                add_noise();
        end
        if (hold)
            hold_go = 1'b1;
        wait_drained();
    endtask

    task automatic write_moderate();
        logic [15:0] deb;
        deb = 16'($urandom_range(40));
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_LONG_PRESS, 16'($urandom_range(900, deb + 50)));
        write_reg(CFG_DOUBLE_CLICK, 16'($urandom_range(400, 30)));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed samples under the reset thresholds
        // single click, reported after the quiet window
        push_sample(3'd1, 32'd100);
        push_sample(3'd0, 32'd200);
        push_sample(3'd0, 32'd400);
        // double click, reported at the second release
        push_sample(3'd3, 32'd1000);
        push_sample(3'd0, 32'd1100);
        push_sample(3'd3, 32'd1150);
        push_sample(3'd0, 32'd1200);
        // long press with growing pattern, a bounce and a partial release
        push_sample(3'd1, 32'd5000);
        push_sample(3'd5, 32'd5100);
        push_sample(3'd4, 32'd5110);
        push_sample(3'd4, 32'd5200);
        push_sample(3'd0, 32'd5800);
        // three clicks close to time zero, reported as a click
        push_sample(3'd1, 32'd30);
        push_sample(3'd0, 32'd60);
        push_sample(3'd1, 32'd90);
        push_sample(3'd0, 32'd120);
        push_sample(3'd1, 32'd145);
        push_sample(3'd0, 32'd170);
        // press just below the wrap point, release just after it
        push_sample(3'd2, 32'hFFFF_FFF0);
        push_sample(3'd0, 32'h0000_0010);
        push_sample(3'd0, 32'd200);
        // all buttons at the top timestamp, ignored bounce at zero
        push_sample(3'd7, 32'hFFFF_FFFF);
        push_sample(3'd0, 32'h0000_0000);
        push_sample(3'd0, 32'h0000_0100);
        push_sample(3'd0, 32'h7FFF_FFFF);
        wait_drained();

        write_moderate();
        run_phase(36, 76, 1'b0);

        // Shortest debounce, longest hold and window; unused index too
        write_reg(CFG_DEBOUNCE, 16'd0);
        write_reg(CFG_LONG_PRESS, 16'hFFFF);
        write_reg(CFG_DOUBLE_CLICK, 16'hFFFF);
        write_reg(CFG_UNUSED, 16'($urandom()));
        run_phase(76, 36, 1'b0);

        // Longest debounce, every release long, no window
        write_reg(CFG_DEBOUNCE, 16'hFFFF);
        write_reg(CFG_LONG_PRESS, 16'd0);
        write_reg(CFG_DOUBLE_CLICK, 16'd0);
        run_phase(0, 0, 1'b0);

        // Back to moderate thresholds with one long receiver hold-off
        write_moderate();
        run_phase(0, 0, 1'b1);

        repeat (SETTLE_PAD) @(negedge clk);
        if (fault_count == 0 && gesture_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
